[src/ptbc_pkg.sv]
// ----------------------------------------------------------------------------
// ptbc_pkg
// Shared widths, types and register codes for the point transform / box crop.
// ----------------------------------------------------------------------------
`default_nettype none

package ptbc_pkg;

  localparam int COORD_W   = 32;
  localparam int COEF_W    = 18;
  localparam int COEF_FRAC = COEF_W - 2;
  localparam int FIELD_W   = 32;               // offsets and box limits
  localparam int MAT_W     = 3 * COEF_W;
  localparam int PROD_W    = COORD_W + COEF_W;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SH_W      = SUM_W - COEF_FRAC;
  localparam int ACC_W     = ((SH_W > FIELD_W) ? SH_W : FIELD_W) + 1;
  localparam int CMP_W     = (COORD_W > FIELD_W) ? COORD_W : FIELD_W;

  localparam int TDATA_W   = ((3 * COORD_W + 7) / 8) * 8;
  localparam int PDATA_W   = 64;
  localparam int PADDR_W   = 6;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_MATRIX_COL_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MATRIX_COL_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MATRIX_COL_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_XY    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_OFFSET_Z     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_X      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_BOUND_Y      = 3'd6;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [SH_W-1:0]    sh_t;
  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [CMP_W-1:0]   cmp_t;

endpackage

`default_nettype wire

[src/point_transform_box_crop_core.sv]
// ----------------------------------------------------------------------------
// point_transform_box_crop_core
// Affine transform of a stream of 3D points, followed by an x/y box crop.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one point per beat, tdata = {z, y, x} (x in the low 32 bits).
//   out_* : transformed, saturated point, same packing; points whose x or y
//           fall outside the open box (lower, upper) are dropped, so the
//           output is a compacted stream in input order.
//   cfg_* : APB-style write/read port, 64-bit data, register i at 8*i.
//           Write only while the stream is idle.
// Throughput: one beat per cycle while out_tready does not stall the output.
//   Stages: input reg, 9 multipliers, column sum with rounding, offset add
//   with saturation, box test into the output reg.
// Stall: each stage holds while the stage after it is full and blocked, so
//   the input keeps flowing into empty stages while a result waits on
//   out_tready; nothing is lost or repeated.
// Reset: synchronous, active low. Clears the pipeline valids and loads the
//   identity matrix, zero offsets and an empty box (nothing passes).
// ----------------------------------------------------------------------------
`default_nettype none

module point_transform_box_crop_core
  import ptbc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input stream
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // point_x, point_y, point_z
  // output stream
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [TDATA_W-1:0]      out_tdata,  // out_x, out_y, out_z
  // configuration
  input  wire logic               cfg_psel,
  input  wire logic               cfg_penable,
  input  wire logic               cfg_pwrite,
  input  wire logic [PADDR_W-1:0] cfg_paddr,
  input  wire logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0]      cfg_prdata,
  output logic                    cfg_pready
);

  localparam sum_t RND = sum_t'(1) <<< (COEF_FRAC - 1);
  localparam acc_t SAT_HI = acc_t'({1'b0, {(COORD_W-1){1'b1}}});
  localparam acc_t SAT_LO = ~SAT_HI;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [MAT_W-1:0]   mat_r [3];
  logic [63:0]        offset_xy_r;
  logic [FIELD_W-1:0] offset_z_r;
  logic [63:0]        bound_x_r;
  logic [63:0]        bound_y_r;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_idx    = cfg_paddr[PADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[0]    <= MAT_W'(1) << COEF_FRAC;
      mat_r[1]    <= MAT_W'(1) << (COEF_FRAC + COEF_W);
      mat_r[2]    <= MAT_W'(1) << (COEF_FRAC + 2 * COEF_W);
      offset_xy_r <= '0;
      offset_z_r  <= '0;
      bound_x_r   <= '0;
      bound_y_r   <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MATRIX_COL_X: mat_r[0]    <= cfg_pwdata[MAT_W-1:0];
        REG_MATRIX_COL_Y: mat_r[1]    <= cfg_pwdata[MAT_W-1:0];
        REG_MATRIX_COL_Z: mat_r[2]    <= cfg_pwdata[MAT_W-1:0];
        REG_OFFSET_XY:    offset_xy_r <= cfg_pwdata;
        REG_OFFSET_Z:     offset_z_r  <= cfg_pwdata[FIELD_W-1:0];
        REG_BOUND_X:      bound_x_r   <= cfg_pwdata;
        REG_BOUND_Y:      bound_y_r   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_MATRIX_COL_X: cfg_prdata = PDATA_W'(mat_r[0]);
      REG_MATRIX_COL_Y: cfg_prdata = PDATA_W'(mat_r[1]);
      REG_MATRIX_COL_Z: cfg_prdata = PDATA_W'(mat_r[2]);
      REG_OFFSET_XY:    cfg_prdata = offset_xy_r;
      REG_OFFSET_Z:     cfg_prdata = PDATA_W'(offset_z_r);
      REG_BOUND_X:      cfg_prdata = bound_x_r;
      REG_BOUND_Y:      cfg_prdata = bound_y_r;
      default:          cfg_prdata = '0;
    endcase
  end

  // per-axis offsets, axis 0..2 = x, y, z
  field_t off_w [3];
  assign off_w[0] = $signed(offset_xy_r[31:0]);
  assign off_w[1] = $signed(offset_xy_r[63:32]);
  assign off_w[2] = $signed(offset_z_r);

  // --------------------------------------------------------------------------
  // Pipeline handshake: a stage loads when it is empty or its data moves on
  // --------------------------------------------------------------------------
  logic v0_r, v1_r, v2_r, v3_r, out_v_r;
  logic rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out   = !out_v_r || out_tready;
  assign rdy3      = !v3_r || rdy_out;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = !v0_r || rdy1;

  // --------------------------------------------------------------------------
  // Stage 0: input register
  // --------------------------------------------------------------------------
  coord_t pt_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (in_tready) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      pt_r[0] <= $signed(in_tdata[0*COORD_W +: COORD_W]);
      pt_r[1] <= $signed(in_tdata[1*COORD_W +: COORD_W]);
      pt_r[2] <= $signed(in_tdata[2*COORD_W +: COORD_W]);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: nine products, prod[axis][input]
  // --------------------------------------------------------------------------
  prod_t prod_nxt [3][3];
  prod_t prod_r   [3][3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int k = 0; k < 3; k++) begin
        prod_nxt[a][k] = prod_t'(pt_r[k]) * prod_t'(coef_t'($signed(mat_r[a][k*COEF_W +: COEF_W])));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && v0_r) begin
      prod_r <= prod_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: column sum, round to nearest (ties up), drop fraction bits
  // --------------------------------------------------------------------------
  sum_t sum_w [3];
  sh_t  sh_nxt [3];
  sh_t  sh_r   [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum_w[a]  = sum_t'(prod_r[a][0]) + sum_t'(prod_r[a][1]) + sum_t'(prod_r[a][2]) + RND;
      sh_nxt[a] = sh_t'(sum_w[a] >>> COEF_FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      sh_r <= sh_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: add offset, saturate to the coordinate width
  // --------------------------------------------------------------------------
  acc_t   acc_w   [3];
  coord_t sat_nxt [3];
  coord_t sat_r   [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      acc_w[a] = acc_t'(sh_r[a]) + acc_t'(off_w[a]);
      if (acc_w[a] > SAT_HI) begin
        sat_nxt[a] = coord_t'(SAT_HI);
      end else if (acc_w[a] < SAT_LO) begin
        sat_nxt[a] = coord_t'(SAT_LO);
      end else begin
        sat_nxt[a] = coord_t'(acc_w[a]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      sat_r <= sat_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: open-box test on saturated x/y, output register
  // --------------------------------------------------------------------------
  cmp_t cx, cy, x_lo, x_hi, y_lo, y_hi;
  logic pass;

  assign cx   = cmp_t'(sat_r[0]);
  assign cy   = cmp_t'(sat_r[1]);
  assign x_lo = cmp_t'(field_t'($signed(bound_x_r[31:0])));
  assign x_hi = cmp_t'(field_t'($signed(bound_x_r[63:32])));
  assign y_lo = cmp_t'(field_t'($signed(bound_y_r[31:0])));
  assign y_hi = cmp_t'(field_t'($signed(bound_y_r[63:32])));
  assign pass = (cx > x_lo) && (cx < x_hi) && (cy > y_lo) && (cy < y_hi);

  logic [TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (rdy_out) begin
      out_v_r <= v3_r && pass;   // dropped points leave a bubble
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && v3_r) begin
      out_data_r <= TDATA_W'({sat_r[2], sat_r[1], sat_r[0]});
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire
